[hw/rtl/cfa_pkg.sv]
// ============================================================================
// cfa_pkg: shared types and constants for the contiguous frame allocator
// Frame map geometry, operation and status codes, word formats and the
// command/status bundles between controller and datapath.
// ============================================================================
package cfa_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int FPW         = 4;                       // frames per map word
    localparam int FPW_W       = $clog2(FPW);
    localparam int WORDS       = MAX_FRAMES / FPW;
    localparam int WORD_AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WORD_W      = 2 * FPW;
    localparam int IDX_W       = WORD_AW + FPW_W;
    localparam int FNUM_W      = 20;
    localparam int CNT_W       = 11;
    localparam int STAT_W      = 3;
    localparam int ACT_W       = 2;
    localparam int CFG_IW      = 2;
    localparam int CMP_W       = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int FCOUNT_RST  = 1024;

    localparam logic [1:0] FS_FREE  = 2'b00;
    localparam logic [1:0] FS_HEAD  = 2'b01;
    localparam logic [1:0] FS_ALLOC = 2'b11;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;

    localparam logic [STAT_W-1:0] STS_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STS_NOSPACE = 3'd1;
    localparam logic [STAT_W-1:0] STS_RANGE   = 3'd2;
    localparam logic [STAT_W-1:0] STS_NOTHEAD = 3'd3;
    localparam logic [STAT_W-1:0] STS_ZERO    = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_INFO  = 2'd2;

    localparam logic [1:0] PH_SCAN = 2'd0;
    localparam logic [1:0] PH_MARK = 2'd1;
    localparam logic [1:0] PH_REL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [FNUM_W-1:0] frame_number;
        logic [CNT_W-1:0]  count;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FNUM_W-1:0] result_frame;
        logic [CNT_W-1:0]  free_frames;
    } out_item_t;

    typedef struct packed {
        logic              load_item;
        logic              clr_start;
        logic              clr_step;
        logic              scan_start;
        logic              mark_start;
        logic              rel_start;
        logic              walk;
        logic [1:0]        phase;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             cfg_hit;
        logic             cnt_zero;
        logic             mark_ok;
        logic             rel_ok;
        logic             clr_last;
        logic             walk_idle;
        logic             found;
        logic             nothead;
        logic             out_free;
    } sts_t;

endpackage

[hw/rtl/contiguous_frame_allocator.sv]
// ============================================================================
// contiguous_frame_allocator: first-fit contiguous frame allocator
// One word in, one result word out per operation, one operation at a time.
// The frame map sits in a RAM holding four frames per word, and every pass
// over it moves one word per cycle. The first-fit scan of an allocate reads
// at most ceil(n/4) map words and stops at the first fit, and marking then
// writes the map words the run spans; mark-inaccessible walks the words
// spanned, and release reads from the head through the first frame past its
// run (or the pool end). Zero-count and range errors skip the map walk.
// After reset and after every configuration write all 256 map words
// (MAX_FRAMES/4) are cleared, during which s_ready stays low. A result
// waiting on m_ready does not hold off the next input word.
// ============================================================================
module contiguous_frame_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cfa_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cfa_pkg::out_item_t         m_data,
    input  logic                       cfg_we,
    input  logic [cfa_pkg::CFG_IW-1:0] cfg_index,
    input  logic [cfa_pkg::FNUM_W-1:0] cfg_wdata
);
    import cfa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cfa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[hw/rtl/cfa_ram.sv]
// ============================================================================
// cfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/cfa_ctrl.sv]
// ============================================================================
// cfa_ctrl: allocator sequencer
// Steps each operation through decode, map walk and result hand-off, and
// runs the map clearing pass after reset and configuration writes.
// ============================================================================
module cfa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cfa_pkg::sts_t sts,
    output cfa_pkg::cmd_t cmd
);
    import cfa_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_MARK   = 3'd4;
    localparam logic [2:0] ST_REL    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                cmd.res_set = 1'b1;
                unique case (sts.action)
                    ACT_ALLOC: begin
                        if (sts.cnt_zero) begin
                            cmd.res_code = STS_ZERO;
                        end else begin
                            cmd.res_set    = 1'b0;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    ACT_MARK: begin
                        if (sts.cnt_zero) begin
                            cmd.res_code = STS_ZERO;
                        end else if (!sts.mark_ok) begin
                            cmd.res_code = STS_RANGE;
                        end else begin
                            cmd.res_code   = STS_OK;
                            cmd.mark_start = 1'b1;
                            state_next     = ST_MARK;
                        end
                    end
                    ACT_RELEASE: begin
                        if (!sts.rel_ok) begin
                            cmd.res_code = STS_RANGE;
                        end else begin
                            cmd.res_set   = 1'b0;
                            cmd.rel_start = 1'b1;
                            state_next    = ST_REL;
                        end
                    end
                    default: begin
                        cmd.res_code = STS_RANGE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.phase = PH_SCAN;
                if (!sts.walk_idle) begin
                    cmd.walk = 1'b1;
                end else if (sts.found) begin
                    cmd.mark_start = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_code   = STS_OK;
                    state_next     = ST_MARK;
                end else begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STS_NOSPACE;
                    state_next   = ST_DONE;
                end
            end
            ST_MARK: begin
                cmd.phase = PH_MARK;
                if (!sts.walk_idle) begin
                    cmd.walk = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_REL: begin
                cmd.phase = PH_REL;
                if (!sts.walk_idle) begin
                    cmd.walk = 1'b1;
                end else begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sts.nothead ? STS_NOTHEAD : STS_OK;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        // a configuration write re-initializes the map
        if (sts.cfg_hit) begin
            cmd           = '0;
            cmd.clr_start = 1'b1;
            state_next    = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/cfa_datapath.sv]
// ============================================================================
// cfa_datapath: frame map, configuration and result registers
// Holds the 2-bit frame map four frames per RAM word, walks it one word per
// cycle for first-fit scan, run marking and run release, keeps the free count.
// ============================================================================
module cfa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cfa_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [cfa_pkg::FNUM_W-1:0]    cfg_wdata,
    input  cfa_pkg::in_item_t             s_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output cfa_pkg::out_item_t            m_data,
    input  cfa_pkg::cmd_t                 cmd,
    output cfa_pkg::sts_t                 sts
);
    import cfa_pkg::*;

    localparam int SUM_W = FNUM_W + 1;

    // configuration
    logic [FNUM_W-1:0]  base_reg;
    logic [CNT_W-1:0]   fcount_reg;
    logic               info_reg;

    // operation
    in_item_t           item_reg;
    logic [WORD_AW-1:0] clr_word_reg;
    logic [WORD_AW-1:0] rd_word_reg;
    logic [WORD_AW-1:0] end_word_reg;
    logic [WORD_AW-1:0] proc_word_reg;
    logic               live_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   run_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               act_reg;
    logic               nothead_reg;
    logic [CNT_W-1:0]   free_count_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [FNUM_W-1:0]  res_frame_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    // derived
    logic [CNT_W-1:0]   pool_n;
    logic [CMP_W-1:0]   n_cmp;
    logic [CMP_W-1:0]   n_last;
    logic [WORD_AW-1:0] pool_end_word;
    logic [SUM_W-1:0]   fnum_x;
    logic [SUM_W-1:0]   base_x;
    logic [SUM_W-1:0]   cnt_x;
    logic [SUM_W-1:0]   n_x;
    logic               below_base;
    logic               mark_ok;
    logic               rel_ok;
    logic [IDX_W-1:0]   item_idx;
    logic [IDX_W-1:0]   first_src;
    logic [IDX_W-1:0]   last_src;
    logic [CNT_W-1:0]   free_take;
    logic [CNT_W-1:0]   free_init;
    logic [CNT_W-1:0]   free_rel;
    logic [CMP_W-1:0]   fc_sum;
    logic               clr_last;
    logic [WORD_W-1:0]  clr_data;

    // walk
    logic [WORD_W-1:0]  rdata;
    logic               scan_go;
    logic               mark_go;
    logic               rel_go;
    logic [CNT_W-1:0]   scan_run;
    logic               scan_hit;
    logic [IDX_W-1:0]   scan_first;
    logic [WORD_W-1:0]  mark_word;
    logic [WORD_W-1:0]  rel_word;
    logic               rel_act;
    logic               rel_bad;
    logic [FPW_W:0]     rel_inc;
    logic               stop_now;
    logic               issue;

    // map memory ports
    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    assign pool_n = (CMP_W'(fcount_reg) > CMP_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                              : fcount_reg;
    assign n_cmp         = CMP_W'(pool_n);
    assign n_last        = n_cmp - CMP_W'(1);
    assign pool_end_word = n_last[IDX_W-1:FPW_W];

    assign fnum_x     = SUM_W'(item_reg.frame_number);
    assign base_x     = SUM_W'(base_reg);
    assign cnt_x      = SUM_W'(item_reg.count);
    assign n_x        = SUM_W'(pool_n);
    assign below_base = fnum_x < base_x;
    assign mark_ok    = !below_base && ((fnum_x + cnt_x) <= (base_x + n_x));
    assign rel_ok     = !below_base && (fnum_x < (base_x + n_x));
    assign item_idx   = IDX_W'(item_reg.frame_number - base_reg);

    assign first_src = (item_reg.action == ACT_ALLOC) ? first_reg : item_idx;
    assign last_src  = IDX_W'(CMP_W'(first_src) + CMP_W'(item_reg.count) - CMP_W'(1));

    assign free_take = (item_reg.count >= free_count_reg) ? '0
                                                          : free_count_reg - item_reg.count;
    assign free_init = pool_n - CNT_W'(info_reg && (pool_n != '0));

    assign clr_last = (clr_word_reg == WORD_AW'(WORDS - 1));

    always_comb begin
        clr_data = '0;
        if ((clr_word_reg == '0) && info_reg && (pool_n != '0)) begin
            clr_data[1:0] = FS_HEAD;
        end
    end

    assign scan_go = cmd.walk && pend_reg && (cmd.phase == PH_SCAN);
    assign mark_go = cmd.walk && pend_reg && (cmd.phase == PH_MARK);
    assign rel_go  = cmd.walk && pend_reg && (cmd.phase == PH_REL);

    // per-word processing for the three walks
    always_comb begin : walk_word
        logic [IDX_W-1:0] f;
        logic [CMP_W-1:0] f_cmp;
        logic [1:0]       st;
        scan_run   = run_reg;
        scan_hit   = 1'b0;
        scan_first = first_reg;
        mark_word  = rdata;
        rel_word   = rdata;
        rel_act    = act_reg;
        rel_bad    = 1'b0;
        rel_inc    = '0;
        for (int j = 0; j < FPW; j++) begin
            f     = {proc_word_reg, FPW_W'(j)};
            f_cmp = CMP_W'(f);
            st    = rdata[2*j +: 2];
            if (!scan_hit && (f_cmp < n_cmp)) begin
                scan_run = (st == FS_FREE) ? scan_run + 1'b1 : '0;
                if (scan_run == item_reg.count) begin
                    scan_hit   = 1'b1;
                    scan_first = IDX_W'(f_cmp + CMP_W'(1) - CMP_W'(item_reg.count));
                end
            end
            if (f == first_reg) begin
                mark_word[2*j +: 2] = FS_HEAD;
            end else if ((f > first_reg) && (f <= last_reg)) begin
                mark_word[2*j +: 2] = FS_ALLOC;
            end
            if (f == item_idx) begin
                if (st != FS_HEAD) begin
                    rel_bad = 1'b1;
                    rel_act = 1'b0;
                end else begin
                    rel_word[2*j +: 2] = FS_FREE;
                    rel_inc = rel_inc + 1'b1;
                end
            end else if ((f > item_idx) && rel_act) begin
                if ((f_cmp < n_cmp) && (st == FS_ALLOC)) begin
                    rel_word[2*j +: 2] = FS_FREE;
                    rel_inc = rel_inc + 1'b1;
                end else begin
                    rel_act = 1'b0;
                end
            end
        end
    end

    assign fc_sum   = CMP_W'(free_count_reg) + CMP_W'(rel_inc);
    assign free_rel = (fc_sum > n_cmp) ? pool_n : CNT_W'(fc_sum);

    assign stop_now = (scan_go && scan_hit) || (rel_go && (rel_bad || !rel_act));
    assign issue    = cmd.walk && live_reg && !stop_now;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = proc_word_reg;
        ram_wdata = mark_word;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_word_reg;
            ram_wdata = clr_data;
        end else if (mark_go) begin
            ram_we    = 1'b1;
        end else if (rel_go && !rel_bad) begin
            ram_we    = 1'b1;
            ram_wdata = rel_word;
        end
    end

    cfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_word_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            fcount_reg   <= CNT_W'(FCOUNT_RST);
            info_reg     <= 1'b0;
            clr_word_reg <= '0;
            live_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE:  base_reg   <= cfg_wdata;
                    CFG_COUNT: fcount_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_INFO:  info_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.clr_start) begin
                clr_word_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_word_reg <= clr_last ? '0 : clr_word_reg + 1'b1;
            end
            pend_reg <= issue;
            if (cmd.scan_start) begin
                live_reg <= (pool_n != '0);
            end else if (cmd.mark_start || cmd.rel_start) begin
                live_reg <= 1'b1;
            end else if (stop_now || (issue && (rd_word_reg == end_word_reg))) begin
                live_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.scan_start) begin
            rd_word_reg  <= '0;
            end_word_reg <= pool_end_word;
            run_reg      <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.mark_start) begin
            first_reg    <= first_src;
            last_reg     <= last_src;
            rd_word_reg  <= first_src[IDX_W-1:FPW_W];
            end_word_reg <= last_src[IDX_W-1:FPW_W];
        end else if (cmd.rel_start) begin
            rd_word_reg  <= item_idx[IDX_W-1:FPW_W];
            end_word_reg <= pool_end_word;
            act_reg      <= 1'b1;
            nothead_reg  <= 1'b0;
        end else begin
            if (issue) begin
                rd_word_reg   <= rd_word_reg + 1'b1;
                proc_word_reg <= rd_word_reg;
            end
            if (scan_go) begin
                run_reg <= scan_run;
                if (scan_hit) begin
                    found_reg <= 1'b1;
                    first_reg <= scan_first;
                end
            end
            if (rel_go) begin
                act_reg <= rel_act;
                if (rel_bad) begin
                    nothead_reg <= 1'b1;
                end
            end
        end
        if (cmd.clr_step && clr_last && !cmd.clr_start) begin
            free_count_reg <= free_init;
        end else if (cmd.mark_start) begin
            free_count_reg <= free_take;
        end else if (rel_go) begin
            free_count_reg <= free_rel;
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_code;
            res_frame_reg  <= ((cmd.res_code == STS_OK) && (item_reg.action == ACT_ALLOC))
                              ? base_reg + FNUM_W'(first_reg) : '0;
        end
        if (cmd.out_load) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.result_frame <= res_frame_reg;
            m_data_reg.free_frames  <= free_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.action    = item_reg.action;
    assign sts.cfg_hit   = cfg_we && ((cfg_index == CFG_BASE) || (cfg_index == CFG_COUNT)
                                      || (cfg_index == CFG_INFO));
    assign sts.cnt_zero  = (item_reg.count == '0);
    assign sts.mark_ok   = mark_ok;
    assign sts.rel_ok    = rel_ok;
    assign sts.clr_last  = clr_last;
    assign sts.walk_idle = !pend_reg && !live_reg;
    assign sts.found     = found_reg;
    assign sts.nothead   = nothead_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

[hw/rtl/cfa_checker.sv]
// ============================================================================
// cfa_checker: port-level checks for the frame allocator
// Watches the top-level ports; bound to the top level below.
// ============================================================================
module cfa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input cfa_pkg::out_item_t         m_data,
    input logic                       cfg_we,
    input logic [cfa_pkg::CFG_IW-1:0] cfg_index
);
    import cfa_pkg::*;

    // one word in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // config write starts the clearing pass
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && ((cfg_index == CFG_BASE) || (cfg_index == CFG_COUNT)
                   || (cfg_index == CFG_INFO)) |=> !s_ready)
        else $error("input ready right after a configuration write");

    a_frame_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STS_OK) |-> (m_data.result_frame == '0))
        else $error("nonzero result frame on a failed operation");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.free_frames) <= MAX_FRAMES))
        else $error("free frame count above pool capacity");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);

[bench/tb_contiguous_frame_allocator.sv]
// ============================================================================
// tb_contiguous_frame_allocator: self-checking bench for the frame allocator
// Drives allocate, release and mark words over several pool settings. An
// in-bench copy of the frame map predicts every result word. Idling on both
// channels is random, and one long receiver stall backs the block up.
// ============================================================================
module tb_contiguous_frame_allocator;

    import cfa_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 2000;

    class pool_scoreboard;
        logic [1:0]  frame_map [MAX_FRAMES];
        int unsigned base;
        int unsigned fcount;
        bit          info;
        int unsigned pool_n;
        int unsigned free_cnt;
        out_item_t   pending_replies [$];
        int unsigned mismatches;

        function void clear_map();
            pool_n = (fcount > MAX_FRAMES) ? MAX_FRAMES : fcount;
            foreach (frame_map[i]) frame_map[i] = FS_FREE;
            free_cnt = pool_n;
            if (info && pool_n > 0) begin
                frame_map[0] = FS_HEAD;
                free_cnt = pool_n - 1;
            end
        endfunction

        function void reset_defaults();
            base = 0;
            fcount = FCOUNT_RST;
            info = 1'b0;
            mismatches = 0;
            clear_map();
        endfunction

        function void apply_cfg(logic [CFG_IW-1:0] idx, logic [FNUM_W-1:0] val);
            case (idx)
                CFG_BASE:  base = 32'(val);
                CFG_COUNT: fcount = 32'(val[CNT_W-1:0]);
                CFG_INFO:  info = val[0];
                default:   return;
            endcase
            clear_map();
        endfunction

        function void mark_run(int unsigned first, int unsigned len);
            frame_map[first] = FS_HEAD;
            for (int unsigned k = 1; k < len; k++) frame_map[first + k] = FS_ALLOC;
        endfunction

        function void take_frames(int unsigned len);
            free_cnt = (len >= free_cnt) ? 0 : free_cnt - len;
        endfunction

        function out_item_t predict_reply(in_item_t w);
            out_item_t   r;
            int unsigned fnum;
            int unsigned cnt;
            int unsigned run;
            int unsigned i;
            int unsigned first;
            int unsigned idx;
            bit          found;
            fnum = 32'(w.frame_number);
            cnt  = 32'(w.count);
            r.status = STS_RANGE;
            r.result_frame = '0;
            case (w.action)
                ACT_ALLOC: begin
                    if (cnt == 0) begin
                        r.status = STS_ZERO;
                    end else begin
                        r.status = STS_NOSPACE;
                        run = 0;
                        found = 1'b0;
                        first = 0;
                        for (i = 0; i < pool_n; i++) begin
                            run = (frame_map[i] == FS_FREE) ? run + 1 : 0;
                            if (run == cnt) begin
                                found = 1'b1;
                                first = i + 1 - cnt;
                                break;
                            end
                        end
                        if (found) begin
                            mark_run(first, cnt);
                            take_frames(cnt);
                            r.result_frame = FNUM_W'(base + first);
                            r.status = STS_OK;
                        end
                    end
                end
                ACT_MARK: begin
                    if (cnt == 0) begin
                        r.status = STS_ZERO;
                    end else if (fnum < base || fnum + cnt > base + pool_n) begin
                        r.status = STS_RANGE;
                    end else begin
                        mark_run(fnum - base, cnt);
                        take_frames(cnt);
                        r.status = STS_OK;
                    end
                end
                ACT_RELEASE: begin
                    if (fnum < base || fnum >= base + pool_n) begin
                        r.status = STS_RANGE;
                    end else begin
                        idx = fnum - base;
                        if (frame_map[idx] != FS_HEAD) begin
                            r.status = STS_NOTHEAD;
                        end else begin
                            do begin
                                frame_map[idx] = FS_FREE;
                                if (free_cnt < pool_n) free_cnt++;
                                idx++;
                            end while (idx < pool_n && frame_map[idx] == FS_ALLOC);
                            r.status = STS_OK;
                        end
                    end
                end
                default: r.status = STS_RANGE;
            endcase
            r.free_frames = CNT_W'(free_cnt);
            return r;
        endfunction

        function void note_request(in_item_t w);
            pending_replies.push_back(predict_reply(w));
        endfunction

        function void check_reply(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.result_frame !== want.result_frame) begin
                $display("%0t: result_frame expected %h got %h",
                         $time, want.result_frame, got.result_frame);
                mismatches++;
            end
            if (got.free_frames !== want.free_frames) begin
                $display("%0t: free_frames expected %0d got %0d",
                         $time, want.free_frames, got.free_frames);
                mismatches++;
            end
        endfunction

        function int pick_head();
            int unsigned start;
            int unsigned j;
            if (pool_n == 0) return -1;
            start = $urandom_range(0, pool_n - 1);
            for (int unsigned i = 0; i < pool_n; i++) begin
                j = (start + i) % pool_n;
                if (frame_map[j] == FS_HEAD) return int'(j);
            end
            return -1;
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [FNUM_W-1:0]   cfg_wdata = '0;

    pool_scoreboard sb;
    int  send_idle_pct = 10;
    int  recv_idle_pct = 85;
    bit  hold_kick = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    contiguous_frame_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // receiver: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_kick;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_reply(m_data);
    end

    task automatic send_word(input in_item_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(w);
    endtask

    task automatic issue(input logic [ACT_W-1:0] act, input logic [FNUM_W-1:0] fnum,
                         input logic [CNT_W-1:0] cnt);
        in_item_t w;
        w.action = act;
        w.frame_number = fnum;
        w.count = cnt;
        send_word(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [FNUM_W-1:0] val);
        while (!s_ready) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.apply_cfg(idx, val);
        // map clear restarts; let s_ready fall before waiting on it
        repeat (2) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic set_pool(input logic [FNUM_W-1:0] b, input logic [FNUM_W-1:0] n,
                            input logic [FNUM_W-1:0] inf);
        drain();
        write_cfg(CFG_BASE, b);
        write_cfg(CFG_COUNT, n);
        write_cfg(CFG_INFO, inf);
    endtask

    function automatic in_item_t random_word();
        in_item_t    w;
        int          head;
        int unsigned pick;
        int unsigned n;
        n = sb.pool_n;
        pick = $urandom_range(0, 99);
        w.action = ACT_ALLOC;
        w.frame_number = FNUM_W'($urandom);
        w.count = CNT_W'($urandom_range(1, 8));
        if (pick < 40) begin
            case ($urandom_range(0, 9))
                0:       w.count = '0;
                1:       w.count = CNT_W'($urandom);
                2, 3:    w.count = CNT_W'($urandom_range(1, n));
                default: w.count = CNT_W'($urandom_range(1, 8));
            endcase
        end else if (pick < 75) begin
            w.action = ACT_RELEASE;
            head = sb.pick_head();
            if (head >= 0) w.frame_number = FNUM_W'(sb.base + head);
        end else if (pick < 85) begin
            w.action = ACT_RELEASE;
            case ($urandom_range(0, 2))
                0:       w.frame_number = FNUM_W'(sb.base + $urandom_range(0, n + 2));
                1:       w.frame_number = FNUM_W'(sb.base - $urandom_range(1, 4));
                default: ;
            endcase
        end else if (pick < 95) begin
            w.action = ACT_MARK;
            case ($urandom_range(0, 7))
                0:       w.count = '0;
                1:       w.count = CNT_W'($urandom);
                2:       w.frame_number = FNUM_W'(sb.base + n - w.count + $urandom_range(0, 1));
                default: w.frame_number = FNUM_W'(sb.base + $urandom_range(0, n - 6));
            endcase
        end else begin
            w.action = ACT_UNUSED;
            w.count = CNT_W'($urandom);
        end
        return w;
    endfunction

    task automatic run_random(input int num);
        repeat (num) send_word(random_word());
    endtask

    initial begin
        sb = new;
        sb.reset_defaults();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default pool: base 0, 1024 frames, nothing reserved
        issue(ACT_ALLOC, 20'd0, 11'd0);
        issue(ACT_MARK, 20'd0, 11'd0);
        issue(ACT_ALLOC, 20'd0, 11'd1024);
        issue(ACT_ALLOC, 20'd0, 11'd1);
        issue(ACT_ALLOC, 20'd0, 11'h7FF);
        issue(ACT_RELEASE, 20'd5, 11'd0);
        issue(ACT_RELEASE, 20'd0, 11'd0);
        issue(ACT_RELEASE, 20'd1024, 11'd0);
        issue(ACT_RELEASE, 20'hFFFFF, 11'd0);
        issue(ACT_UNUSED, 20'hFFFFF, 11'h7FF);
        issue(ACT_MARK, 20'd1000, 11'd24);
        issue(ACT_MARK, 20'd1000, 11'd25);
        issue(ACT_MARK, 20'hFFFFF, 11'h7FF);
        issue(ACT_ALLOC, 20'd0, 11'd1000);
        issue(ACT_MARK, 20'd10, 11'd5);
        issue(ACT_RELEASE, 20'd0, 11'd0);
        issue(ACT_RELEASE, 20'd10, 11'd0);
        issue(ACT_RELEASE, 20'd1000, 11'd0);
        issue(ACT_ALLOC, 20'd0, 11'd3);

        // smallest pool at the top of the frame space, frame 0 reserved
        set_pool(20'hFFFFC, 20'd8, 20'd1);
        issue(ACT_RELEASE, 20'hFFFFB, 11'd0);
        issue(ACT_ALLOC, 20'd0, 11'd8);
        issue(ACT_ALLOC, 20'd0, 11'd2);
        issue(ACT_ALLOC, 20'd0, 11'd2);
        issue(ACT_ALLOC, 20'd0, 11'd2);
        issue(ACT_MARK, 20'hFFFFC, 11'd4);
        issue(ACT_RELEASE, 20'hFFFFC, 11'd0);
        run_random(85);

        drain();
        send_idle_pct = 85;
        recv_idle_pct <= 10;
        set_pool(FNUM_W'($urandom), 20'd64, 20'd0);
        run_random(160);

        set_pool(FNUM_W'($urandom), 20'd2047, 20'd1);
        run_random(150);

        drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_pool(20'd3, 20'd13, 20'd0);
        run_random(120);

        set_pool(20'h80000, 20'd1024, 20'd0);
        run_random(60);
        hold_kick <= ~hold_kick;
        run_random(140);

        drain();
        repeat (600) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
